// ===== design/rfgd_pkg.sv =====
// Shared types and constants of the RTU frame gap delimiter.
// Used by the front, queue, back, top level and checker; depends on nothing.
package rfgd_pkg;

  // Default largest frame held in one bank.
  localparam int unsigned MAX_FRAME_BYTES_DEF = 256;

  // Field widths fixed by the request and result formats.
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned CAP_W      = 16;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned FLEN_W     = 9;
  localparam int unsigned S_TDATA_W  = 56;
  localparam int unsigned M_TDATA_W  = 24;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Small queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Configuration register indexes and reset values.
  localparam logic [CFG_INDEX_W-1:0] CFG_INTERCHAR = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_GAP = 2'd1;
  localparam logic [STAMP_W-1:0] INTERCHAR_RST = 32'd750;
  localparam logic [STAMP_W-1:0] FRAME_GAP_RST = 32'd1750;

  // Request kinds.
  typedef enum logic [REQ_W-1:0] {
    REQ_FEED  = 2'd0,
    REQ_POLL  = 2'd1,
    REQ_TAKE  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_NO_FRAME  = 3'd0,
    ST_READY     = 3'd1,
    ST_BUSY      = 3'd2,
    ST_TIMEOUT   = 3'd3,
    ST_OVERFLOW  = 3'd4,
    ST_TOO_SMALL = 3'd5,
    ST_INVALID   = 3'd6
  } status_t;

  // Frame store operation carried with each result.
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  // Command handed from the front to the back (store address travels beside it).
  typedef struct packed {
    op_t                op;
    logic [BYTE_W-1:0]  wdata;
    status_t            status;
    logic [FLEN_W-1:0]  flen;
    logic               last;
  } cmd_t;

endpackage

// ===== design/rfgd_front.sv =====
// Front part: configuration registers, frame tracking state and request decode.
// Depends on rfgd_pkg; emits one command per accepted request to the queue.
module rfgd_front #(
  parameter int unsigned MAX_FRAME_BYTES = rfgd_pkg::MAX_FRAME_BYTES_DEF,
  parameter int unsigned AW = $clog2(MAX_FRAME_BYTES) + 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rfgd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rfgd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             req_take,
  input  logic [rfgd_pkg::REQ_W-1:0]       req_type,
  input  logic [rfgd_pkg::BYTE_W-1:0]      data_byte,
  input  logic [rfgd_pkg::STAMP_W-1:0]     time_stamp_us,
  input  logic [rfgd_pkg::CAP_W-1:0]       reader_capacity,
  output rfgd_pkg::cmd_t                   cmd,
  output logic [AW-1:0]                    cmd_addr
);
  import rfgd_pkg::*;

  localparam int unsigned PW = AW - 1;
  localparam int unsigned CW = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_FRAME_BYTES);

  logic [STAMP_W-1:0] interchar_limit;
  logic [STAMP_W-1:0] frame_gap;

  logic              receive_bank, receive_bank_next;
  logic [CW-1:0]     receive_count, receive_count_next;
  logic [CW-1:0]     done_count, done_count_next;
  logic [CW-1:0]     read_position, read_position_next;
  logic [STAMP_W-1:0] last_stamp, last_stamp_next;
  logic              receiving, receiving_next;
  logic              ready, ready_next;

  logic [STAMP_W-1:0] gap;
  logic               cfg_bad;
  logic               gap_ends;
  logic               gap_breaks;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      interchar_limit <= INTERCHAR_RST;
      frame_gap       <= FRAME_GAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INTERCHAR: interchar_limit <= cfg_data;
        CFG_FRAME_GAP: frame_gap       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Wrapping gap since the last stored byte and the two timing decisions.
  assign gap        = time_stamp_us - last_stamp;
  assign cfg_bad    = (interchar_limit == '0) || (frame_gap <= interchar_limit);
  assign gap_ends   = gap >= frame_gap;
  assign gap_breaks = gap > interchar_limit;

  // Request decode and next state.
  always_comb begin
    receive_bank_next  = receive_bank;
    receive_count_next = receive_count;
    done_count_next    = done_count;
    read_position_next = read_position;
    last_stamp_next    = last_stamp;
    receiving_next     = receiving;
    ready_next         = ready;
    cmd.op     = OP_NONE;
    cmd.wdata  = data_byte;
    cmd.status = ST_NO_FRAME;
    cmd.flen   = '0;
    cmd.last   = 1'b0;
    cmd_addr   = {receive_bank, receive_count[PW-1:0]};

    if (cfg_bad) begin
      cmd.status = ST_INVALID;
    end else begin
      case (req_t'(req_type))
        REQ_FEED: begin
          if (ready) begin
            cmd.status = ST_BUSY;
          end else if (!receiving || gap_ends || gap_breaks) begin
            // Start a new frame with this byte, finishing the old one first
            // when the gap is a frame gap.
            if (receiving && gap_ends) begin
              done_count_next    = receive_count;
              read_position_next = '0;
              ready_next         = 1'b1;
              receive_bank_next  = ~receive_bank;
              cmd.status         = ST_READY;
            end else if (receiving) begin
              cmd.status = ST_TIMEOUT;
            end
            cmd.op             = OP_WRITE;
            cmd_addr           = {receive_bank_next, {PW{1'b0}}};
            receive_count_next = CW'(1);
            last_stamp_next    = time_stamp_us;
            receiving_next     = 1'b1;
          end else if (receive_count >= MAX_COUNT) begin
            receive_count_next = '0;
            receiving_next     = 1'b0;
            cmd.status         = ST_OVERFLOW;
          end else begin
            cmd.op             = OP_WRITE;
            receive_count_next = receive_count + CW'(1);
            last_stamp_next    = time_stamp_us;
          end
        end
        REQ_POLL: begin
          if (ready) begin
            cmd.status = ST_READY;
          end else if (receiving && gap_ends) begin
            done_count_next    = receive_count;
            read_position_next = '0;
            ready_next         = 1'b1;
            receive_bank_next  = ~receive_bank;
            receive_count_next = '0;
            receiving_next     = 1'b0;
            cmd.status         = ST_READY;
          end
        end
        REQ_TAKE: begin
          if (ready) begin
            cmd.flen = FLEN_W'(done_count);
            if (CAP_W'(reader_capacity) < CAP_W'(done_count)) begin
              cmd.status = ST_TOO_SMALL;
            end else begin
              cmd.status = ST_READY;
              cmd_addr   = {~receive_bank, read_position[PW-1:0]};
              if (read_position < done_count) begin
                cmd.op = OP_READ;
              end
              if (read_position + CW'(1) >= done_count) begin
                cmd.last           = 1'b1;
                ready_next         = 1'b0;
                done_count_next    = '0;
                read_position_next = '0;
              end else begin
                read_position_next = read_position + CW'(1);
              end
            end
          end
        end
        REQ_CLEAR: begin
          receive_bank_next  = 1'b0;
          receive_count_next = '0;
          done_count_next    = '0;
          read_position_next = '0;
          last_stamp_next    = '0;
          receiving_next     = 1'b0;
          ready_next         = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Frame tracking state, updated on each transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      receive_bank  <= 1'b0;
      receive_count <= '0;
      done_count    <= '0;
      read_position <= '0;
      last_stamp    <= '0;
      receiving     <= 1'b0;
      ready         <= 1'b0;
    end else if (req_take) begin
      receive_bank  <= receive_bank_next;
      receive_count <= receive_count_next;
      done_count    <= done_count_next;
      read_position <= read_position_next;
      last_stamp    <= last_stamp_next;
      receiving     <= receiving_next;
      ready         <= ready_next;
    end
  end

endmodule

// ===== design/rfgd_queue.sv =====
// Short first-in first-out queue between the front and the back.
// Depends on rfgd_pkg for its depth; the entry is an opaque bit vector.
module rfgd_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             not_empty,
  output logic             not_full
);
  import rfgd_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign not_empty = count != '0;
  assign not_full  = count != CNT_W'(QUEUE_DEPTH);
  assign head_data = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule

// ===== design/rfgd_back.sv =====
// Back part: ping-pong frame store and the registered result stage.
// Depends on rfgd_pkg; executes queued commands strictly in order.
module rfgd_back #(
  parameter int unsigned MAX_FRAME_BYTES = rfgd_pkg::MAX_FRAME_BYTES_DEF,
  parameter int unsigned AW = $clog2(MAX_FRAME_BYTES) + 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  input  rfgd_pkg::cmd_t                 cmd,
  input  logic [AW-1:0]                  cmd_addr,
  output logic                           cmd_pop,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [rfgd_pkg::M_TDATA_W-1:0] m_tdata,
  output logic [rfgd_pkg::STATUS_W-1:0]  m_tuser,
  output logic                           m_tlast
);
  import rfgd_pkg::*;

  localparam int unsigned STORE_DEPTH = 2 ** AW;

  logic [BYTE_W-1:0] store [STORE_DEPTH];
  logic [BYTE_W-1:0] rd_data;
  logic              out_valid;
  cmd_t              out_cmd;
  logic [BYTE_W-1:0] out_byte;

  // Take the next command when the result register is free or draining.
  assign cmd_pop = cmd_valid && (!out_valid || m_tready);

  // Frame store: one access per command, writes and reads kept in order.
  always_ff @(posedge clk) begin
    if (cmd_pop && (cmd.op == OP_WRITE)) begin
      store[cmd_addr] <= cmd.wdata;
    end
    if (cmd_pop && (cmd.op == OP_READ)) begin
      rd_data <= store[cmd_addr];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_pop) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      out_cmd <= cmd;
    end
  end

  assign out_byte = (out_cmd.op == OP_READ) ? rd_data : '0;
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(M_TDATA_W - FLEN_W - BYTE_W){1'b0}}, out_cmd.flen, out_byte};
  assign m_tuser  = out_cmd.status;
  assign m_tlast  = out_cmd.last;

endmodule

// ===== design/rtu_frame_gap_delimiter.sv =====
// Top level of the RTU frame gap delimiter: front, queue and back.
// Depends on rfgd_pkg, rfgd_front, rfgd_queue and rfgd_back.
//
// Usage:
// Requests enter on the s_ stream: s_tuser holds the request kind (feed,
// poll, take, clear) and s_tdata the byte, timestamp and reader capacity.
// Every request produces exactly one result on the m_ stream: m_tuser holds
// the status, m_tdata the frame byte and frame length, m_tlast marks the
// final byte of a frame on a take.
// The cfg channel writes the inter-character limit (index 0) and the frame
// gap (index 1); it is always ready and should be used while idle.
// Each accepted request is written into the queue, then loaded into the
// result register, from which it transfers on the m_ stream.
// Throughput: one request per cycle while the queue is not full, set by
// the single-port store in the back: one write or one read per command.
// A four-entry queue separates the two parts. When the receiver stalls, the
// result register holds and the queue fills; s_tready drops once it is full.
// Synchronous reset restores the default timing registers, clears the frame
// tracking state and empties the queue and result register. The frame store
// is not cleared; only written entries are ever read.
module rtu_frame_gap_delimiter #(
  parameter int unsigned MAX_FRAME_BYTES = rfgd_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // Request stream.
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // s_tdata: data_byte [7:0], time_stamp_us [39:8], reader_capacity [55:40]
  input  logic [rfgd_pkg::S_TDATA_W-1:0]   s_tdata,
  // s_tuser: req_type [1:0]
  input  logic [rfgd_pkg::REQ_W-1:0]       s_tuser,
  // Result stream.
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // m_tdata: frame_byte [7:0], frame_length [16:8], zero fill [23:17]
  output logic [rfgd_pkg::M_TDATA_W-1:0]   m_tdata,
  // m_tuser: status [2:0]
  output logic [rfgd_pkg::STATUS_W-1:0]    m_tuser,
  output logic                             m_tlast,
  // Configuration write channel.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rfgd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rfgd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rfgd_pkg::*;

  localparam int unsigned AW = $clog2(MAX_FRAME_BYTES) + 1;
  localparam int unsigned QW = $bits(cmd_t) + AW;

  logic          req_xfer;
  cmd_t          front_cmd;
  logic [AW-1:0] front_addr;
  logic [QW-1:0] head;
  cmd_t          back_cmd;
  logic [AW-1:0] back_addr;
  logic          q_not_empty;
  logic          q_not_full;
  logic          q_pop;

  assign cfg_ready = 1'b1;
  assign s_tready  = q_not_full;
  assign req_xfer  = s_tvalid && s_tready;

  // Request decode and frame tracking.
  rfgd_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
    .AW(AW)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .req_take       (req_xfer),
    .req_type       (s_tuser),
    .data_byte      (s_tdata[7:0]),
    .time_stamp_us  (s_tdata[39:8]),
    .reader_capacity(s_tdata[55:40]),
    .cmd            (front_cmd),
    .cmd_addr       (front_addr)
  );

  // Command queue.
  rfgd_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (req_xfer),
    .push_data({front_cmd, front_addr}),
    .pop      (q_pop),
    .head_data(head),
    .not_empty(q_not_empty),
    .not_full (q_not_full)
  );

  assign back_cmd  = cmd_t'(head[QW-1:AW]);
  assign back_addr = head[AW-1:0];

  // Frame store and result register.
  rfgd_back #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
    .AW(AW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(q_not_empty),
    .cmd      (back_cmd),
    .cmd_addr (back_addr),
    .cmd_pop  (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== design/rfgd_checker.sv =====
// Port-level checker for the RTU frame gap delimiter, bound to the top level.
// Depends on rfgd_pkg for status codes and widths.
module rfgd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [rfgd_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [rfgd_pkg::STATUS_W-1:0]  m_tuser,
  input logic                           m_tlast
);
  import rfgd_pkg::*;

  // Reset empties the result register.
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A stalled result holds its contents.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // The final byte of a frame only comes with a successful take.
  a_last_is_ready: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser == ST_READY)
    else $error("last byte without ready status");

  // Only takes report a frame length, and only delivered bytes are nonzero.
  a_len_only_take: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_READY) |-> (m_tdata[7:0] == '0) &&
      ((m_tuser == ST_TOO_SMALL) || (m_tdata[16:8] == '0)))
    else $error("byte or length on a result that carries none");

endmodule

bind rtu_frame_gap_delimiter rfgd_checker u_rfgd_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);

// ===== verif/rtu_frame_gap_delimiter_tb.sv =====
// Self-checking testbench for the RTU frame gap delimiter.
// Drives request transfers and timing register writes, predicts each result
// and checks it; depends on rfgd_pkg and rtu_frame_gap_delimiter.
`timescale 1ns / 100ps

module rtu_frame_gap_delimiter_tb;
  import rfgd_pkg::*;

  localparam int unsigned FRAME_MAX = MAX_FRAME_BYTES_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // Kinds of silence placed before a timestamped request.
  typedef enum {GAP_JOIN, GAP_BREAK, GAP_END} gap_kind_t;

  typedef struct {
    status_t          status;
    logic [7:0]       fbyte;
    logic [8:0]       flen;
    logic             last;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [REQ_W-1:0] s_tuser = REQ_FEED;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0] m_tuser;
  logic m_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_INTERCHAR;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predicted block state and timing registers.
  logic [7:0]  gap_store [0:2*FRAME_MAX-1];
  int unsigned rx_bank;
  int unsigned rx_count;
  int unsigned ready_len;
  int unsigned take_pos;
  logic [31:0] prev_stamp;
  bit          rx_active;
  bit          frame_waiting;
  logic [31:0] ic_limit;
  logic [31:0] end_gap;

  frame_result_t awaited_responses[$];

  int unsigned send_idle_pct = 17;
  int unsigned recv_idle_pct = 74;
  int unsigned hold_left = 0;
  int unsigned accepted_count = 0;
  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;

  rtu_frame_gap_delimiter u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: random stalls, or a counted hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare every result transfer with the oldest prediction.
  always @(posedge clk) begin : check_responses
    frame_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_responses.size() == 0) begin
        $error("result with nothing expected: status %0d", m_tuser);
        fail_count++;
      end else begin
        want = awaited_responses.pop_front();
        if (m_tuser !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, m_tuser);
          fail_count++;
        end
        if (m_tdata[7:0] !== want.fbyte) begin
          $error("frame_byte mismatch: expected %0d, actual %0d", want.fbyte, m_tdata[7:0]);
          fail_count++;
        end
        if (m_tdata[16:8] !== want.flen) begin
          $error("frame_length mismatch: expected %0d, actual %0d", want.flen, m_tdata[16:8]);
          fail_count++;
        end
        if (m_tlast !== want.last) begin
          $error("last_byte mismatch: expected %0d, actual %0d", want.last, m_tlast);
          fail_count++;
        end
      end
    end
  end

  function automatic void clear_tracking();
    rx_bank = 0;
    rx_count = 0;
    ready_len = 0;
    take_pos = 0;
    prev_stamp = '0;
    rx_active = 1'b0;
    frame_waiting = 1'b0;
  endfunction

  function automatic void open_frame(input logic [7:0] b, input logic [31:0] stamp);
    gap_store[rx_bank * FRAME_MAX] = b;
    rx_count = 1;
    prev_stamp = stamp;
    rx_active = 1'b1;
  endfunction

  // Hand the received frame to the reader and switch banks.
  function automatic void seal_frame();
    ready_len = rx_count;
    take_pos = 0;
    frame_waiting = 1'b1;
    rx_bank = rx_bank ^ 1;
    rx_count = 0;
    rx_active = 1'b0;
  endfunction

  // Work out the result of one accepted request and update the tracked state.
  task automatic compute_frame_response(input req_t kind, input logic [7:0] b,
                                        input logic [31:0] stamp, input logic [15:0] cap);
    frame_result_t r;
    logic [31:0] gap;
    r.status = ST_NO_FRAME;
    r.fbyte = '0;
    r.flen = '0;
    r.last = 1'b0;
    gap = stamp - prev_stamp;
    if (ic_limit == 0 || end_gap <= ic_limit) begin
      r.status = ST_INVALID;
    end else begin
      case (kind)
        REQ_FEED: begin
          if (frame_waiting) begin
            r.status = ST_BUSY;
          end else if (!rx_active) begin
            open_frame(b, stamp);
          end else if (gap >= end_gap) begin
            seal_frame();
            open_frame(b, stamp);
            r.status = ST_READY;
          end else if (gap > ic_limit) begin
            open_frame(b, stamp);
            r.status = ST_TIMEOUT;
          end else if (rx_count >= FRAME_MAX) begin
            rx_count = 0;
            rx_active = 1'b0;
            r.status = ST_OVERFLOW;
          end else begin
            gap_store[rx_bank * FRAME_MAX + rx_count] = b;
            rx_count++;
            prev_stamp = stamp;
          end
        end
        REQ_POLL: begin
          if (frame_waiting) begin
            r.status = ST_READY;
          end else if (rx_active && gap >= end_gap) begin
            seal_frame();
            r.status = ST_READY;
          end
        end
        REQ_TAKE: begin
          if (frame_waiting) begin
            r.flen = 9'(ready_len);
            if (cap < ready_len) begin
              r.status = ST_TOO_SMALL;
            end else begin
              r.status = ST_READY;
              r.fbyte = gap_store[(rx_bank ^ 1) * FRAME_MAX + take_pos];
              if (take_pos + 1 >= ready_len) begin
                r.last = 1'b1;
                frame_waiting = 1'b0;
                ready_len = 0;
                take_pos = 0;
              end else begin
                take_pos++;
              end
            end
          end
        end
        default: begin
          clear_tracking();
        end
      endcase
    end
    awaited_responses.push_back(r);
  endtask

  // Choose a silence of the given kind for the current timing registers.
  function automatic logic [31:0] pick_gap(input gap_kind_t k);
    case (k)
      GAP_JOIN: begin
        return ($urandom_range(3) == 0) ? ic_limit : $urandom_range(ic_limit, 0);
      end
      GAP_BREAK: begin
        if (end_gap - ic_limit < 2) return ic_limit;
        return $urandom_range(end_gap - 1, ic_limit + 1);
      end
      default: begin
        if ($urandom_range(3) == 0) return end_gap;
        return end_gap + $urandom_range(32'hFFFF_FFFF - end_gap, 0);
      end
    endcase
  endfunction

  // Offer one request and wait for its transfer; valid stays high afterwards.
  task automatic send_request(input req_t kind, input logic [7:0] b,
                              input logic [31:0] stamp, input logic [15:0] cap);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {cap, stamp, b};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    compute_frame_response(kind, b, stamp, cap);
    accepted_count++;
  endtask

  // Stop offering and let every outstanding result arrive.
  task automatic wait_for_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (awaited_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_INTERCHAR) ic_limit = value;
    else if (idx == CFG_FRAME_GAP) end_gap = value;
  endtask

  task automatic apply_timing(input logic [31:0] ic, input logic [31:0] fg);
    wait_for_idle();
    write_register(CFG_INTERCHAR, ic);
    write_register(CFG_FRAME_GAP, fg);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_noise();
    req_t kind;
    logic [31:0] stamp;
    kind = req_t'($urandom_range(3));
    if (kind == REQ_CLEAR && $urandom_range(7) != 0) kind = REQ_POLL;
    case ($urandom_range(3))
      0: stamp = $urandom;
      1: stamp = prev_stamp + pick_gap(GAP_JOIN);
      2: stamp = prev_stamp + pick_gap(GAP_BREAK);
      default: stamp = prev_stamp + pick_gap(GAP_END);
    endcase
    send_request(kind, $urandom, stamp, $urandom);
  endtask

  // Read out a waiting frame, with short buffers and stray requests mixed in.
  task automatic hand_out_frame();
    while (frame_waiting) begin
      case ($urandom_range(11))
        0, 1: send_request(REQ_TAKE, $urandom, $urandom, $urandom_range(ready_len - 1, 0));
        2: send_request(REQ_FEED, $urandom, $urandom, $urandom);
        3: send_request(REQ_POLL, $urandom, $urandom, $urandom);
        default: send_request(REQ_TAKE, $urandom, $urandom, $urandom_range(16'hFFFF, ready_len));
      endcase
    end
  endtask

  // One frame with random content, sometimes broken or overflowing, sometimes preceded by noise.
  task automatic send_random_frame();
    int unsigned len;
    if ($urandom_range(4) == 0) repeat ($urandom_range(3, 1)) send_noise();
    if (rx_active) send_request(REQ_POLL, $urandom, prev_stamp + pick_gap(GAP_END), $urandom);
    hand_out_frame();
    len = ($urandom_range(99) == 0) ? $urandom_range(FRAME_MAX + 2, FRAME_MAX - 4)
                                    : $urandom_range(8, 1);
    send_request(REQ_FEED, $urandom, prev_stamp + pick_gap(GAP_END), $urandom);
    repeat (len - 1) begin
      send_request(REQ_FEED, $urandom,
                   prev_stamp + pick_gap(($urandom_range(19) == 0) ? GAP_BREAK : GAP_JOIN),
                   $urandom);
    end
    if ($urandom_range(3) == 0)
      send_request(REQ_POLL, $urandom, prev_stamp + pick_gap(GAP_JOIN), $urandom);
    send_request(REQ_POLL, $urandom, prev_stamp + pick_gap(GAP_END), $urandom);
    hand_out_frame();
  endtask

  // Boundaries of the gap rules, waiting frames, short buffers and stamp wrap.
  task automatic test_directed_basics();
    send_request(REQ_TAKE, 8'h00, 32'd0, 16'd0);
    send_request(REQ_POLL, 8'h00, 32'd0, 16'd0);
    send_request(REQ_FEED, 8'h00, 32'd100, 16'd0);
    send_request(REQ_FEED, 8'hFF, 32'd850, 16'd0);
    send_request(REQ_FEED, 8'hA5, 32'd1601, 16'd0);
    send_request(REQ_FEED, 8'h5A, 32'd1611, 16'd0);
    send_request(REQ_POLL, 8'h00, 32'd3360, 16'd0);
    send_request(REQ_POLL, 8'h00, 32'd3361, 16'd0);
    send_request(REQ_POLL, 8'h00, 32'd9999, 16'd0);
    send_request(REQ_FEED, 8'h77, 32'd9999, 16'd0);
    send_request(REQ_TAKE, 8'h00, 32'd0, 16'd1);
    send_request(REQ_TAKE, 8'h00, 32'd0, 16'd2);
    send_request(REQ_TAKE, 8'h00, 32'd0, 16'hFFFF);
    send_request(REQ_TAKE, 8'h00, 32'd0, 16'hFFFF);
    // The timestamp wraps inside one frame.
    send_request(REQ_FEED, 8'h3C, 32'hFFFF_FF00, 16'd0);
    send_request(REQ_FEED, 8'hC3, 32'h0000_0010, 16'd0);
    send_request(REQ_FEED, 8'h81, 32'h0000_06E6, 16'd0);
    send_request(REQ_FEED, 8'h7E, 32'h0000_06E7, 16'd0);
    send_request(REQ_TAKE, 8'h00, 32'd0, 16'd2);
    send_request(REQ_TAKE, 8'h00, 32'd0, 16'd2);
    send_request(REQ_FEED, 8'h42, 32'h0000_06E7, 16'd0);
    send_request(REQ_CLEAR, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(REQ_TAKE, 8'h00, 32'd0, 16'hFFFF);
    send_request(REQ_POLL, 8'h00, 32'hFFFF_FFFF, 16'd0);
  endtask

  // A bad timing pair rejects every request and leaves the partial frame intact.
  task automatic test_invalid_timing();
    apply_timing(INTERCHAR_RST, FRAME_GAP_RST);
    send_request(REQ_CLEAR, 8'h00, 32'd0, 16'd0);
    send_request(REQ_FEED, 8'h11, 32'd1000, 16'd0);
    send_request(REQ_FEED, 8'h22, 32'd1200, 16'd0);
    apply_timing(32'd1000, 32'd1000);
    send_request(REQ_FEED, 8'h33, 32'd1300, 16'd0);
    send_request(REQ_POLL, 8'h00, 32'hF000_0000, 16'd0);
    send_request(REQ_TAKE, 8'h00, 32'd0, 16'hFFFF);
    send_request(REQ_CLEAR, 8'h00, 32'd0, 16'd0);
    apply_timing(32'd2000, 32'd1000);
    send_request(REQ_FEED, 8'h44, 32'd1300, 16'd0);
    send_request(REQ_POLL, 8'h00, 32'h8000_0000, 16'd0);
    apply_timing(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_TAKE, 8'h00, 32'd0, 16'd0);
    send_request(REQ_CLEAR, 8'h00, 32'd0, 16'd0);
    apply_timing(INTERCHAR_RST, FRAME_GAP_RST);
    send_request(REQ_FEED, 8'h55, 32'd1300, 16'd0);
    send_request(REQ_POLL, 8'h00, 32'd3050, 16'd0);
    hand_out_frame();
  endtask

  // Smallest and largest legal timing pairs.
  task automatic test_timing_extremes();
    apply_timing(32'd1, 32'd2);
    send_request(REQ_CLEAR, 8'h00, 32'd0, 16'd0);
    send_request(REQ_FEED, 8'h01, 32'd5, 16'd0);
    send_request(REQ_FEED, 8'h02, 32'd5, 16'd0);
    send_request(REQ_FEED, 8'h03, 32'd6, 16'd0);
    send_request(REQ_FEED, 8'h04, 32'd8, 16'd0);
    hand_out_frame();
    send_request(REQ_POLL, 8'h00, 32'd9, 16'd0);
    send_request(REQ_POLL, 8'h00, 32'd10, 16'd0);
    hand_out_frame();
    apply_timing(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_request(REQ_FEED, 8'h80, 32'd0, 16'd0);
    send_request(REQ_FEED, 8'h08, 32'hFFFF_FFFE, 16'd0);
    send_request(REQ_FEED, 8'hF0, 32'hFFFF_FFFD, 16'd0);
    hand_out_frame();
    send_request(REQ_CLEAR, 8'h00, 32'd0, 16'd0);
  endtask

  // A frame that runs past the bank size, then one of exactly the bank size.
  task automatic test_frame_overflow();
    apply_timing(INTERCHAR_RST, FRAME_GAP_RST);
    send_request(REQ_CLEAR, 8'h00, 32'd0, 16'd0);
    repeat (FRAME_MAX + 1)
      send_request(REQ_FEED, $urandom, prev_stamp + pick_gap(GAP_JOIN), $urandom);
    repeat (FRAME_MAX)
      send_request(REQ_FEED, $urandom, prev_stamp + pick_gap(GAP_JOIN), $urandom);
    send_request(REQ_POLL, 8'h00, prev_stamp + end_gap, 16'd0);
    send_request(REQ_TAKE, 8'h00, 32'd0, 16'(FRAME_MAX - 1));
    repeat (FRAME_MAX) send_request(REQ_TAKE, $urandom, $urandom, 16'(FRAME_MAX));
  endtask

  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                     input int unsigned n_items);
    logic [31:0] ic;
    int unsigned stop_at;
    wait_for_idle();
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int s = 0; s < 4; s++) begin
      case (s)
        0: apply_timing(INTERCHAR_RST, FRAME_GAP_RST);
        1: apply_timing(32'd1, 32'd2);
        2: apply_timing(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        default: begin
          ic = $urandom_range(100000, 1);
          apply_timing(ic, ic + $urandom_range(200000, 1));
        end
      endcase
      stop_at = accepted_count + n_items / 4;
      while (accepted_count < stop_at) send_random_frame();
    end
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_receiver_hold();
    int unsigned stop_at;
    apply_timing(INTERCHAR_RST, FRAME_GAP_RST);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    hold_left = 300;
    stop_at = accepted_count + 40;
    while (accepted_count < stop_at) send_random_frame();
    wait_for_idle();
  endtask

  // The sender pauses mid-frame until every result is back, then continues.
  task automatic test_sender_pause();
    send_request(REQ_CLEAR, 8'h00, 32'd0, 16'd0);
    repeat (3) send_request(REQ_FEED, $urandom, prev_stamp + pick_gap(GAP_JOIN), $urandom);
    wait_for_idle();
    repeat (2) send_request(REQ_FEED, $urandom, prev_stamp + pick_gap(GAP_JOIN), $urandom);
    wait_for_idle();
    send_request(REQ_POLL, 8'h00, prev_stamp + pick_gap(GAP_END), 16'd0);
    hand_out_frame();
  endtask

  initial begin
    clear_tracking();
    ic_limit = INTERCHAR_RST;
    end_gap = FRAME_GAP_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_basics();
    test_invalid_timing();
    test_timing_extremes();
    test_frame_overflow();
    test_random_traffic(17, 74, 200);
    test_random_traffic(74, 17, 200);
    test_random_traffic(0, 0, 200);
    test_receiver_hold();
    test_sender_pause();

    wait_for_idle();
    repeat (10) @(posedge clk);
    if (awaited_responses.size() != 0) begin
      $error("%0d results never arrived", awaited_responses.size());
      fail_count++;
    end
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/rfgd_pkg.sv
design/rfgd_front.sv
design/rfgd_queue.sv
design/rfgd_back.sv
design/rtu_frame_gap_delimiter.sv
design/rfgd_checker.sv
verif/rtu_frame_gap_delimiter_tb.sv
